@@ design/assert_macros.svh @@
// assertion macros shared by the framer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

@@ design/mbrf_pkg.sv @@
// types, codes and helper functions of the modbus rtu request framer
package mbrf_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 64;

  typedef enum logic [2:0] {
    OP_RD_INPUTS   = 3'd0,
    OP_RD_COILS    = 3'd1,
    OP_RD_IN_REGS  = 3'd2,
    OP_RD_HOLDING  = 3'd3,
    OP_WR_COILS    = 3'd4,
    OP_WR_HOLDING  = 3'd5
  } opcode_e;

  localparam logic [2:0] OP_LAST = OP_WR_HOLDING;

  localparam logic [7:0] FC_RD_INPUTS  = 8'h02;
  localparam logic [7:0] FC_RD_COILS   = 8'h01;
  localparam logic [7:0] FC_RD_IN_REGS = 8'h04;
  localparam logic [7:0] FC_RD_HOLDING = 8'h03;
  localparam logic [7:0] FC_WR_COILS   = 8'h0F;
  localparam logic [7:0] FC_WR_HOLDING = 8'h10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [11:0] REPLY_MAX = 12'hFFF;
  localparam logic [11:0] REPLY_WRITE = 12'd8;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  station_address;
    logic [15:0] start_address;
    logic [10:0] item_count;
  } req_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [11:0] reply_length;
    logic        write_request;
    logic        too_long;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_ERROR
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic op_ok;
    logic too_long;
    logic last;
  } dp_sts_t;

  function automatic logic [7:0] fcode(input logic [2:0] op);
    logic [7:0] f;
    case (op)
      OP_RD_INPUTS:  f = FC_RD_INPUTS;
      OP_RD_COILS:   f = FC_RD_COILS;
      OP_RD_IN_REGS: f = FC_RD_IN_REGS;
      OP_RD_HOLDING: f = FC_RD_HOLDING;
      OP_WR_COILS:   f = FC_WR_COILS;
      OP_WR_HOLDING: f = FC_WR_HOLDING;
      default:       f = 8'h00;
    endcase
    return f;
  endfunction

  // one byte through the reflected crc-16, lsb first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/mbrf_ctrl.sv @@
// controller state machine of the modbus rtu request framer
`include "assert_macros.svh"
module mbrf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output mbrf_pkg::dp_cmd_t cmd,
  input  mbrf_pkg::dp_sts_t sts
);
  import mbrf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
        // unused opcodes are taken and dropped
        if (req_valid && sts.op_ok) begin
          state_next = sts.too_long ? ST_ERROR : ST_FRAME;
        end
      end
      ST_FRAME: begin
        rsp_valid   = 1'b1;
        cmd.advance = rsp_ready;
        if (rsp_ready && sts.last) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERROR: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_one_side, clk, rst, !(req_ready && rsp_valid), "input and output open together")
  `ASSERT_NEXT(a_err_single, clk, rst, state == ST_ERROR && rsp_ready, state == ST_IDLE,
               "error result not single")
  `ASSERT_NEXT(a_frame_end, clk, rst, state == ST_FRAME && rsp_ready && sts.last,
               state == ST_IDLE, "frame did not end on last byte")

endmodule

@@ design/mbrf_dp.sv @@
// datapath of the modbus rtu request framer: request fields, byte index, crc
`include "assert_macros.svh"
module mbrf_dp #(
  parameter int MAX_FRAME_BYTES = mbrf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mbrf_pkg::req_t    req,
  output mbrf_pkg::rsp_t    rsp,
  input  mbrf_pkg::dp_cmd_t cmd,
  output mbrf_pkg::dp_sts_t sts
);
  import mbrf_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES);

  // request decode
  logic        in_wr;
  logic [12:0] in_payload;
  logic [12:0] in_len;
  logic [12:0] in_reply_w;
  logic [11:0] in_reply;
  logic        in_too_long;

  always_comb begin
    in_wr = (req.opcode == OP_WR_COILS) || (req.opcode == OP_WR_HOLDING);
    in_payload = 13'd0;
    if (req.opcode == OP_WR_COILS) begin
      in_payload = (13'(req.item_count) + 13'd7) >> 3;
    end else if (req.opcode == OP_WR_HOLDING) begin
      in_payload = {1'b0, req.item_count, 1'b0};
    end
    in_len = in_wr ? (13'd9 + in_payload) : 13'd8;
    if (req.opcode == OP_RD_INPUTS || req.opcode == OP_RD_COILS) begin
      in_reply_w = 13'd5 + ((13'(req.item_count) + 13'd7) >> 3);
    end else begin
      in_reply_w = 13'd5 + {1'b0, req.item_count, 1'b0};
    end
    if (in_wr) begin
      in_reply = REPLY_WRITE;
    end else if (in_reply_w > 13'(REPLY_MAX)) begin
      in_reply = REPLY_MAX;
    end else begin
      in_reply = in_reply_w[11:0];
    end
    in_too_long = in_wr && (in_len > 13'(MAX_FRAME_BYTES));
  end

  // latched request
  logic [2:0]       opcode;
  logic [7:0]       station;
  logic [15:0]      start_addr;
  logic [10:0]      count;
  logic [7:0]       byte_count;
  logic [11:0]      reply;
  logic             wr;
  logic             err;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] crc_lo_idx;
  logic [IDX_W-1:0] idx;
  logic [15:0]      crc;
  logic [7:0]       cur_byte;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode     <= req.opcode;
      station    <= req.station_address;
      start_addr <= req.start_address;
      count      <= req.item_count;
      byte_count <= in_payload[7:0];
      reply      <= in_reply;
      wr         <= in_wr;
      err        <= in_too_long;
      last_idx   <= IDX_W'(in_len - 13'd1);
      crc_lo_idx <= IDX_W'(in_len - 13'd2);
      idx        <= '0;
      crc        <= CRC_INIT;
    end else if (cmd.advance) begin
      if (idx < crc_lo_idx) begin
        crc <= crc_update(crc, cur_byte);
      end
      idx <= idx + IDX_W'(1);
    end
  end

  always_comb begin
    if (idx == last_idx) begin
      cur_byte = crc[15:8];
    end else if (idx == crc_lo_idx) begin
      cur_byte = crc[7:0];
    end else begin
      case (idx)
        IDX_W'(0): cur_byte = station;
        IDX_W'(1): cur_byte = fcode(opcode);
        IDX_W'(2): cur_byte = start_addr[15:8];
        IDX_W'(3): cur_byte = start_addr[7:0];
        IDX_W'(4): cur_byte = {5'd0, count[10:8]};
        IDX_W'(5): cur_byte = count[7:0];
        IDX_W'(6): cur_byte = byte_count;
        default:   cur_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    if (err) begin
      rsp.frame_byte    = 8'h00;
      rsp.last_byte     = 1'b1;
      rsp.reply_length  = REPLY_WRITE;
      rsp.write_request = 1'b1;
      rsp.too_long      = 1'b1;
    end else begin
      rsp.frame_byte    = cur_byte;
      rsp.last_byte     = (idx == last_idx);
      rsp.reply_length  = reply;
      rsp.write_request = wr;
      rsp.too_long      = 1'b0;
    end
  end

  assign sts.op_ok    = (req.opcode <= OP_LAST);
  assign sts.too_long = in_too_long;
  assign sts.last     = (idx == last_idx);

  `ASSERT_ALWAYS(a_cmd_excl, clk, rst, !(cmd.load && cmd.advance), "load and advance together")
  `ASSERT_NEXT(a_load_init, clk, rst, cmd.load, idx == '0 && crc == CRC_INIT,
               "load did not restart index and crc")
  `ASSERT_ALWAYS(a_idx_range, clk, rst, !cmd.advance || idx <= last_idx,
                 "byte index ran past frame end")

endmodule

@@ design/modbus_rtu_request_framer_top.sv @@
// top level of the modbus rtu request framer
// Usage:
//   req channel (req_valid/req_ready, payload req) takes one master request:
//   opcode, station address, start address and item count.
//   rsp channel (rsp_valid/rsp_ready, payload rsp) gives the rtu frame, one
//   byte per beat in wire order, crc low byte before crc high byte; each beat
//   also carries the expected reply length and the write flag, and last_byte
//   marks the final crc byte.
//   A write whose frame exceeds MAX_FRAME_BYTES gives one error beat
//   (too_long set, last_byte set) and no frame. Opcodes 6 and 7 are taken
//   and give no beat.
// Timing:
//   the first byte is offered the cycle after the request is taken; one byte
//   leaves per cycle while rsp_ready is high. The crc register is updated by
//   one byte per data beat, up to the crc bytes, in the datapath, and a new
//   request is taken only once the last beat of the previous one has gone.
//   When the receiver stalls the current beat holds unchanged.
// Reset: rst returns the controller to idle; no beat is pending after reset.
module modbus_rtu_request_framer_top #(
  parameter int MAX_FRAME_BYTES = mbrf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mbrf_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mbrf_pkg::rsp_t rsp
);
  import mbrf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mbrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mbrf_dp #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule
